/* rtl/pf_pkg.sv */
// Shared types, constants and control structs for the Playfair stream encipherer.
// Used by pf_ctrl, pf_datapath and playfair_encrypt_stream; depends on nothing.

package pf_pkg;

    typedef logic [4:0] t_letter;   // letter 0..25, a = 0
    typedef logic [4:0] t_cell;     // square cell 0..24, row-major
    typedef logic [2:0] t_coord;    // row or column 0..4

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_KEY_END = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;
    localparam logic [1:0] KIND_MSG_END = 2'd3;

    localparam t_letter LETTER_I    = 5'd8;
    localparam t_letter LETTER_J    = 5'd9;
    localparam t_letter LETTER_X    = 5'd23;
    localparam t_letter LETTER_LAST = 5'd25;
    localparam t_cell   CELLS       = 5'd25;
    localparam t_coord  SIDE_LAST   = 3'd4;
    localparam logic [6:0] ASCII_A  = 7'd97;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // process the input word presented now
        logic fill_step;    // place the sweep letter, advance the sweep
        logic fill_done;    // square complete
        logic place_rd;     // read letter_place
        logic place_sel_b;  // 0: first letter of pair, 1: second
        logic cap_pa;       // hold position of first letter
        logic calc;         // work out the two ciphertext cells
        logic sq_rd;        // read the square
        logic sq_sel_b;     // 0: first cipher cell, 1: second
        logic out_load;     // load the output register
        logic out_last;     // pair_last of the loaded word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_fill;   // word is a key end on an unfinished square
        logic start_pair;   // word closes a pair
        logic fill_last;    // sweep is on the last letter
        logic out_free;     // output register can take a word this cycle
    } t_stat;

endpackage

/* rtl/playfair_encrypt_stream.sv */
// Playfair stream encipherer, top level: joins pf_ctrl and pf_datapath.
// Depends on pf_pkg, pf_ctrl and pf_datapath.
//
// Usage: send key words (kind 0) to build the 5x5 square, then one key-end
// word (kind 1), then plaintext words (kind 2) and a message-end word (kind 3).
// Letters are case folded, j reads as i, other characters are dropped.
// Every closed pair gives two output words, pair_last low then high.
// Input channel: i_in_valid / o_in_ready; output: o_out_valid / i_out_ready.
// Sequencing: a key, plaintext-opening or dropped word leaves the controller in
// S_IDLE. A key end sweeps the alphabet, one letter a cycle. A word that closes
// a pair runs two position lookups and two square reads on one read port each,
// plus the cell calculation. The first cipher letter is loaded into the output
// register in S_RD_B while the second is read; the second is loaded in S_PUT_B.
// If the receiver stalls, the block holds in the pair sequence until the
// output register frees; the next input word is taken while the second
// letter waits. Reset clears the square state: a new key must follow.

module playfair_encrypt_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cipher_char,
    output logic       o_pair_last
);

    pf_pkg::t_cmd  cmd;
    pf_pkg::t_stat stat;

    pf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_char_in     (i_char_in),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_char (o_cipher_char),
        .o_pair_last   (o_pair_last)
    );

endmodule

/* rtl/pf_ctrl.sv */
// Controller state machine for the Playfair stream encipherer.
// Depends on pf_pkg; drives pf_datapath through t_cmd and reads t_stat.

module pf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pf_pkg::t_stat i_stat,
    output pf_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FILL   = 8'b0000_0010,
        S_LOOK_A = 8'b0000_0100,
        S_LOOK_B = 8'b0000_1000,
        S_CALC   = 8'b0001_0000,
        S_RD_A   = 8'b0010_0000,
        S_RD_B   = 8'b0100_0000,
        S_PUT_B  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.start_fill) begin
                        n_state = S_FILL;
                    end else if (i_stat.start_pair) begin
                        n_state = S_LOOK_A;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.fill_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LOOK_A: begin
                o_cmd.place_rd = 1'b1;
                n_state = S_LOOK_B;
            end
            S_LOOK_B: begin
                o_cmd.place_rd    = 1'b1;
                o_cmd.place_sel_b = 1'b1;
                o_cmd.cap_pa      = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_RD_A;
            end
            S_RD_A: begin
                o_cmd.sq_rd = 1'b1;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                // hold the first letter's load and the second read until the output register frees
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.sq_rd    = 1'b1;
                    o_cmd.sq_sel_b = 1'b1;
                    n_state = S_PUT_B;
                end
            end
            S_PUT_B: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/pf_datapath.sv */
// Datapath of the Playfair stream encipherer: square and position memories,
// pairing state, cipher cell arithmetic and output register. Depends on pf_pkg.

module pf_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_char_in,
    input  pf_pkg::t_cmd  i_cmd,
    output pf_pkg::t_stat o_stat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [6:0]    o_cipher_char,
    output logic          o_pair_last
);

    function automatic pf_pkg::t_coord cell_row(input pf_pkg::t_cell p);
        pf_pkg::t_coord r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic pf_pkg::t_coord cell_col(input pf_pkg::t_cell p);
        logic [4:0] base;
        logic [4:0] diff;
        base = ({2'b00, cell_row(p)} << 2) + {2'b00, cell_row(p)};
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic pf_pkg::t_cell cell_index(input pf_pkg::t_coord row,
                                                 input pf_pkg::t_coord col);
        return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic pf_pkg::t_coord coord_inc(input pf_pkg::t_coord x);
        return (x == pf_pkg::SIDE_LAST) ? 3'd0 : x + 3'd1;
    endfunction

    // memories, written only once per placement
    pf_pkg::t_letter square_mem [25];
    pf_pkg::t_cell   place_mem  [26];

    logic [25:0]     r_used;
    pf_pkg::t_cell   r_fill_count;
    pf_pkg::t_letter r_fill_k;
    pf_pkg::t_letter r_pend_letter;
    logic            r_pend_valid;
    logic            r_sq_ready;
    pf_pkg::t_letter r_a;
    pf_pkg::t_letter r_b;
    pf_pkg::t_cell   r_place_q;
    pf_pkg::t_cell   r_pa;
    pf_pkg::t_cell   r_oa;
    pf_pkg::t_cell   r_ob;
    pf_pkg::t_letter r_sq_q;
    logic            r_out_valid;
    logic [6:0]      r_out_char;
    logic            r_out_last;

    // input decode
    logic [7:0]      fold_c;
    logic            in_is_ltr;
    pf_pkg::t_letter in_ltr;
    logic            is_key;
    logic            text_pair;
    logic            end_pair;
    logic            same_ltr;

    always_comb begin
        fold_c = i_char_in;
        if (i_char_in >= 8'd65 && i_char_in <= 8'd90) begin
            fold_c = i_char_in + 8'd32;
        end
        in_is_ltr = (fold_c >= 8'd97) && (fold_c <= 8'd122);
        in_ltr    = 5'(fold_c - 8'd97);
        if (in_ltr == pf_pkg::LETTER_J) begin
            in_ltr = pf_pkg::LETTER_I;
        end
    end

    assign is_key    = (i_kind == pf_pkg::KIND_KEY);
    assign same_ltr  = (in_ltr == r_pend_letter);
    assign text_pair = (i_kind == pf_pkg::KIND_TEXT) && r_sq_ready && in_is_ltr
                       && r_pend_valid;
    assign end_pair  = (i_kind == pf_pkg::KIND_MSG_END) && r_sq_ready && r_pend_valid;

    assign o_stat.start_fill = (i_kind == pf_pkg::KIND_KEY_END) && !r_sq_ready;
    assign o_stat.start_pair = text_pair || end_pair;
    assign o_stat.fill_last  = (r_fill_k == pf_pkg::LETTER_LAST);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // placement: a key letter on accept, or the sweep letter during fill
    logic            key_acc;
    logic            clr;
    logic            place_req;
    pf_pkg::t_letter place_ltr;
    logic [25:0]     used_eff;
    pf_pkg::t_cell   fill_eff;
    logic            place_ok;

    always_comb begin
        key_acc   = i_cmd.accept && is_key;
        clr       = key_acc && r_sq_ready;
        place_req = 1'b0;
        place_ltr = in_ltr;
        if (key_acc) begin
            place_req = in_is_ltr;
        end else if (i_cmd.fill_step) begin
            place_req = (r_fill_k != pf_pkg::LETTER_J);
            place_ltr = r_fill_k;
        end
        used_eff = clr ? '0 : r_used;
        fill_eff = clr ? '0 : r_fill_count;
        place_ok = place_req && !used_eff[place_ltr] && (fill_eff < pf_pkg::CELLS);
    end

    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            square_mem[fill_eff] <= place_ltr;
            place_mem[place_ltr] <= fill_eff;
        end
        if (i_cmd.place_rd) begin
            r_place_q <= place_mem[i_cmd.place_sel_b ? r_b : r_a];
        end
        if (i_cmd.sq_rd) begin
            r_sq_q <= square_mem[i_cmd.sq_sel_b ? r_ob : r_oa];
        end
    end

    // cipher cells from the two positions
    pf_pkg::t_coord r1, c1, r2, c2;
    pf_pkg::t_cell  n_oa, n_ob;

    always_comb begin
        r1 = cell_row(r_pa);
        c1 = cell_col(r_pa);
        r2 = cell_row(r_place_q);
        c2 = cell_col(r_place_q);
        if (r1 == r2) begin
            n_oa = cell_index(r1, coord_inc(c1));
            n_ob = cell_index(r2, coord_inc(c2));
        end else if (c1 == c2) begin
            n_oa = cell_index(coord_inc(r1), c1);
            n_ob = cell_index(coord_inc(r2), c2);
        end else begin
            n_oa = cell_index(r1, c2);
            n_ob = cell_index(r2, c1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.start_pair) begin
            r_a <= r_pend_letter;
            r_b <= (text_pair && !same_ltr) ? in_ltr : pf_pkg::LETTER_X;
        end
        if (i_cmd.cap_pa) begin
            r_pa <= r_place_q;
        end
        if (i_cmd.calc) begin
            r_oa <= n_oa;
            r_ob <= n_ob;
        end
        if (i_cmd.out_load) begin
            r_out_char <= pf_pkg::ASCII_A + {2'b00, r_sq_q};
            r_out_last <= i_cmd.out_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_fill_count  <= '0;
            r_fill_k      <= '0;
            r_pend_letter <= '0;
            r_pend_valid  <= 1'b0;
            r_sq_ready    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (key_acc || i_cmd.fill_step) begin
                r_used       <= used_eff | (place_ok ? (26'd1 << place_ltr) : 26'd0);
                r_fill_count <= fill_eff + {4'd0, place_ok};
            end
            if (clr) begin
                r_sq_ready    <= 1'b0;
                r_pend_valid  <= 1'b0;
                r_pend_letter <= '0;
            end
            if (i_cmd.accept && o_stat.start_fill) begin
                r_fill_k <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill_k <= r_fill_k + 5'd1;
            end
            if (i_cmd.fill_done) begin
                r_sq_ready    <= 1'b1;
                r_pend_valid  <= 1'b0;
                r_pend_letter <= '0;
            end
            if (i_cmd.accept && (i_kind == pf_pkg::KIND_TEXT) && r_sq_ready
                && in_is_ltr && !r_pend_valid) begin
                r_pend_letter <= in_ltr;
                r_pend_valid  <= 1'b1;
            end
            // a doubled letter keeps the pair open
            if (i_cmd.accept && ((text_pair && !same_ltr) || end_pair)) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_char = r_out_char;
    assign o_pair_last   = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= pf_pkg::CELLS)
        else $error("fill count past the square");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_ready |-> (r_fill_count == pf_pkg::CELLS))
        else $error("square marked ready while not full");

    a_pend_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_sq_ready)
        else $error("open pair without a complete square");

    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> !r_sq_ready)
        else $error("fill sweep on a complete square");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while full");

endmodule

/* test/playfair_encrypt_stream_tb.sv */
// Self-checking testbench for playfair_encrypt_stream: a directed run, then random
// key/plaintext streams with random stalls, checked word by word against a predictor.
// Depends on pf_pkg and the playfair_encrypt_stream RTL.

module playfair_encrypt_stream_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 5;
    localparam int TEXT_WORDS = 1100;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_cipher_word;

    // Square state, open pair and the ciphertext still owed by the block.
    class cipher_tracker;
        bit [4:0]     grid[25];
        bit [4:0]     spot_of[26];
        bit           placed[26];
        int unsigned  filled;
        bit [4:0]     open_letter;
        bit           open_valid;
        bit           square_done;
        int unsigned  mismatches;
        t_cipher_word expected_cipher[$];

        function new();
            foreach (placed[k]) placed[k] = 1'b0;
            filled = 0;
            open_letter = '0;
            open_valid = 1'b0;
            square_done = 1'b0;
            mismatches = 0;
        endfunction

        // Letter 0..25 with j folded onto i, or -1 for a non-letter.
        function int fold(bit [7:0] c);
            int v;
            v = c;
            if (v >= 65 && v <= 90) v += 32;
            if (v < 97 || v > 122) return -1;
            v -= 97;
            if (v == pf_pkg::LETTER_J) v = pf_pkg::LETTER_I;
            return v;
        endfunction

        function void place(int l);
            if (placed[l] || filled >= pf_pkg::CELLS) return;
            placed[l] = 1'b1;
            grid[filled] = 5'(l);
            spot_of[l] = 5'(filled);
            filled++;
        endfunction

        function void encipher_pair(bit [4:0] a, bit [4:0] b);
            int pa, pb, r1, c1, r2, c2, oa, ob;
            pa = spot_of[a];
            pb = spot_of[b];
            r1 = pa / SIDE;
            c1 = pa % SIDE;
            r2 = pb / SIDE;
            c2 = pb % SIDE;
            if (r1 == r2) begin
                oa = r1 * SIDE + (c1 + 1) % SIDE;
                ob = r2 * SIDE + (c2 + 1) % SIDE;
            end else if (c1 == c2) begin
                oa = ((r1 + 1) % SIDE) * SIDE + c1;
                ob = ((r2 + 1) % SIDE) * SIDE + c2;
            end else begin
                oa = r1 * SIDE + c2;
                ob = r2 * SIDE + c1;
            end
            expected_cipher.push_back('{ch: 7'(pf_pkg::ASCII_A + grid[oa]), last: 1'b0});
            expected_cipher.push_back('{ch: 7'(pf_pkg::ASCII_A + grid[ob]), last: 1'b1});
        endfunction

        // Returns 1 when the word changes state or causes ciphertext.
        function bit note_word(bit [1:0] kind, bit [7:0] c);
            int l;
            bit was_done;
            l = fold(c);
            case (kind)
                pf_pkg::KIND_KEY: begin
                    was_done = square_done;
                    if (square_done) begin
                        foreach (placed[k]) placed[k] = 1'b0;
                        filled = 0;
                        open_valid = 1'b0;
                        open_letter = '0;
                        square_done = 1'b0;
                    end
                    if (l >= 0) place(l);
                    return (l >= 0) || was_done;
                end
                pf_pkg::KIND_KEY_END: begin
                    if (square_done) return 1'b0;
                    for (int k = 0; k < 26; k++) begin
                        if (k != pf_pkg::LETTER_J) place(k);
                    end
                    square_done = 1'b1;
                    open_valid = 1'b0;
                    open_letter = '0;
                    return 1'b1;
                end
                pf_pkg::KIND_TEXT: begin
                    if (!square_done || l < 0) return 1'b0;
                    if (!open_valid) begin
                        open_letter = 5'(l);
                        open_valid = 1'b1;
                    end else if (5'(l) == open_letter) begin
                        // doubled letter: pad with x, keep the letter open
                        encipher_pair(open_letter, pf_pkg::LETTER_X);
                    end else begin
                        open_valid = 1'b0;
                        encipher_pair(open_letter, 5'(l));
                    end
                    return 1'b1;
                end
                default: begin
                    if (!square_done || !open_valid) return 1'b0;
                    open_valid = 1'b0;
                    encipher_pair(open_letter, pf_pkg::LETTER_X);
                    return 1'b1;
                end
            endcase
        endfunction

        function void check_word(logic [6:0] ch, logic last);
            t_cipher_word want;
            if (expected_cipher.size() == 0) begin
                $display("%0t: unexpected word, actual cipher_char %0d pair_last %0d",
                         $realtime, ch, last);
                mismatches++;
                return;
            end
            want = expected_cipher.pop_front();
            if (ch !== want.ch) begin
                $display("%0t: cipher_char expected %0d actual %0d", $realtime, want.ch, ch);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: pair_last expected %0d actual %0d", $realtime, want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_cipher.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind = pf_pkg::KIND_KEY;
    logic [7:0] i_char_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [6:0] o_cipher_char;
    logic       o_pair_last;

    cipher_tracker tracker = new;
    int unsigned   words_sent = 0;
    int unsigned   results_seen = 0;
    bit            calm = 1'b0;
    bit            have_key = 1'b0;

    playfair_encrypt_stream i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_char (o_cipher_char),
        .o_pair_last   (o_pair_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // Offer one word, idling first at random; valid stays high after acceptance.
    task automatic send_word(logic [1:0] kind, logic [7:0] c);
        while (!calm && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_char_in <= c;
        do @(posedge i_clk); while (!o_in_ready);
        void'(tracker.note_word(kind, c));
        words_sent++;
    endtask

    task automatic send_str(logic [1:0] kind, string s);
        for (int k = 0; k < s.len(); k++) send_word(kind, s[k]);
    endtask

    // Random letter in random case, or a random byte about noise_pct percent of the time.
    function automatic logic [7:0] pick_char(int noise_pct);
        if ($urandom_range(99) < noise_pct) return 8'($urandom);
        return ($urandom_range(1) ? 8'd65 : 8'd97) + 8'($urandom_range(25));
    endfunction

    task automatic run_message();
        int n;
        int r;
        int prev;
        logic [7:0] c;
        if (!have_key || $urandom_range(3) == 0) begin
            n = $urandom_range(12);
            repeat (n) send_word(pf_pkg::KIND_KEY, pick_char(10));
            send_word(pf_pkg::KIND_KEY_END, 8'($urandom));
            have_key = 1'b1;
        end
        n = $urandom_range(30, 1);
        prev = -1;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 12) c = 8'($urandom);
            else if (r < 30 && prev >= 0) c = 8'd97 + 8'(prev);
            else if (r < 38) c = ($urandom_range(1) ? "X" : "x");
            else c = pick_char(0);
            prev = tracker.fold(c);
            send_word(pf_pkg::KIND_TEXT, c);
        end
        if ($urandom_range(4) != 0) send_word(pf_pkg::KIND_MSG_END, 8'($urandom));
    endtask

    // Receiver: random stalls, plus one long hold-off to back up the block.
    initial begin
        int unsigned hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                tracker.check_word(o_cipher_char, o_pair_last);
                results_seen++;
            end
            if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 21);
            end
        end
    end

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Text and message end before any square exists: dropped.
        send_word(pf_pkg::KIND_TEXT, "q");
        send_word(pf_pkg::KIND_MSG_END, 8'hA5);
        // Key with case folding, j as i, repeats and non-letters.
        send_str(pf_pkg::KIND_KEY, "PlJ");
        send_word(pf_pkg::KIND_KEY, 8'h00);
        send_str(pf_pkg::KIND_KEY, "ai");
        send_word(pf_pkg::KIND_KEY, 8'hFF);
        send_str(pf_pkg::KIND_KEY, "Z");
        send_word(pf_pkg::KIND_KEY_END, 8'h00);
        send_word(pf_pkg::KIND_KEY_END, 8'hFF);
        // Doubled b, x closing a pair, x padded onto x, message end with nothing open.
        send_str(pf_pkg::KIND_TEXT, "BbxX");
        send_word(pf_pkg::KIND_MSG_END, 8'h00);
        send_word(pf_pkg::KIND_MSG_END, 8'h00);
        send_word(pf_pkg::KIND_TEXT, "!");
        // Same row with wrap, same column with wrap, rectangle.
        send_str(pf_pkg::KIND_TEXT, "azpuly");

        while (words_sent < TEXT_WORDS) begin
            calm = (words_sent >= 400 && words_sent < 600);
            if (!drained && words_sent >= 750) begin
                // Hold the sender until the block has returned everything.
                drained = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (tracker.pending() != 0);
            end
            if ($urandom_range(99) < 85) begin
                run_message();
            end else begin
                repeat ($urandom_range(4, 1)) send_word(2'($urandom), 8'($urandom));
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (30) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
